/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
// Clocked on clk, disabled while arst_n is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never be true out of reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* hw/rtl/ckcrc_pkg.sv */
// Package for the cksum CRC-32 stream block: types, constants, CRC byte step.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ckcrc_pkg;

	localparam int DEFAULT_COUNT_BITS = 48;
	localparam int OUT_COUNT_W        = 48;
	localparam int QUEUE_DEPTH        = 4;
	localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W            = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] CRC_POLY = 32'h04C11DB7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_file;
	} item_t;

	typedef struct packed {
		logic folding;
	} bk_status_t;

	typedef enum logic [0:0] {
		ST_RUN,
		ST_FOLD
	} bk_state_t;

	// MSB-first CRC-32 update by one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] s, input logic [7:0] c);
		logic [31:0] r;
		r = s ^ {c, 24'h000000};
		for (int k = 0; k < 8; k++) begin
			if (r[31]) begin
				r = {r[30:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[30:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/ckcrc_front.sv */
// Front end: accepts requests, drops those that carry neither byte nor end
// marker, and queues the rest. Depends on ckcrc_pkg.
`timescale 1ns / 1ps

module ckcrc_front import ckcrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	input  logic       end_of_file,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	item_t               queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QFILL_W-1:0]  fill_q;
	logic                push;

	assign in_ready = (fill_q != QFILL_W'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready && (byte_valid || end_of_file);
	assign q_valid  = (fill_q != '0);
	assign q_item   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{data_byte: data_byte, byte_valid: byte_valid,
				end_of_file: end_of_file};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + QFILL_W'(1);
			end else if (q_pop && !push) begin
				fill_q <= fill_q - QFILL_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/ckcrc_back.sv */
// Back end: CRC and byte count update, length folding at end of file,
// and the result register. Depends on ckcrc_pkg.
`timescale 1ns / 1ps

module ckcrc_back import ckcrc_pkg::*; #(
	parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  item_t                  q_item,
	output logic                   q_pop,
	output bk_status_t             status,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [31:0]            checksum,
	output logic [OUT_COUNT_W-1:0] byte_count,
	output logic                   count_overflow
);

	localparam int EXT_W = COUNT_BITS + OUT_COUNT_W;

	bk_state_t               state_q;
	bk_state_t               state_d;
	logic [31:0]             crc_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic                    sat_q;
	logic [COUNT_BITS-1:0]   fold_q;
	logic                    out_valid_q;
	logic [31:0]             checksum_q;
	logic [OUT_COUNT_W-1:0]  byte_count_q;
	logic                    count_overflow_q;

	logic                    count_full;
	logic [COUNT_BITS-1:0]   count_next;
	logic                    fold_done;
	logic                    out_free;
	logic                    take_byte;
	logic                    start_fold;
	logic                    fold_step;
	logic                    emit;
	logic [EXT_W-1:0]        count_ext;

	assign count_full = &count_q;
	assign count_next = count_full ? count_q : count_q + COUNT_BITS'(1);
	assign fold_done  = (fold_q == '0);
	assign out_free   = !out_valid_q || out_ready;
	assign count_ext  = EXT_W'(count_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (q_valid && q_item.end_of_file) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (fold_done && out_free) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		fold_step  = 1'b0;
		emit       = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				q_pop = q_valid;
			end
			ST_FOLD: begin
				fold_step = !fold_done;
				emit      = fold_done && out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
		take_byte  = q_pop && q_item.byte_valid;
		start_fold = q_pop && q_item.end_of_file;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			crc_q       <= '0;
			count_q     <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_byte) begin
				crc_q   <= crc_byte(crc_q, q_item.data_byte);
				count_q <= count_next;
				sat_q   <= sat_q | count_full;
			end else if (fold_step) begin
				crc_q <= crc_byte(crc_q, fold_q[7:0]);
			end else if (emit) begin
				crc_q   <= '0;
				count_q <= '0;
				sat_q   <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_fold) begin
			fold_q <= take_byte ? count_next : count_q;
		end else if (fold_step) begin
			fold_q <= fold_q >> 8;
		end
		if (emit) begin
			checksum_q       <= ~crc_q;
			byte_count_q     <= count_ext[OUT_COUNT_W-1:0];
			count_overflow_q <= sat_q;
		end
	end

	assign status.folding  = (state_q == ST_FOLD);
	assign out_valid       = out_valid_q;
	assign checksum        = checksum_q;
	assign byte_count      = byte_count_q;
	assign count_overflow  = count_overflow_q;

endmodule

/* hw/rtl/posix_cksum_crc32_stream.sv */
// Streaming POSIX cksum CRC-32: one request per file byte, one result per file.
// Input: in_valid/in_ready with data_byte, byte_valid, end_of_file. A request
// with byte_valid takes the byte into the CRC and the byte count; a request
// with end_of_file closes the file after its byte (if any). A request with
// neither flag is taken and has no effect.
// Output: out_valid/out_ready with checksum, byte_count, count_overflow, one
// result per end of file. The count saturates at COUNT_BITS and raises
// count_overflow.
// Throughput: one byte per cycle while the back end is not folding a length; the
// queue keeps taking requests meanwhile until full. At end of file the back end
// folds the length in, one byte at a time and low byte first, up to the highest
// nonzero one (at most COUNT_BITS/8, rounded up), then loads the result register
// once the output register is free.
// A four-entry request queue sits between front and back; while the receiver
// stalls, the back end holds its result and the queue keeps accepting until full.
// Reset (arst_n low) empties the queue and clears CRC, count and result valid.
// Depends on ckcrc_pkg, ckcrc_front, ckcrc_back, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module posix_cksum_crc32_stream import ckcrc_pkg::*; #(
	parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	input  logic                   byte_valid,
	input  logic                   end_of_file,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [31:0]            checksum,
	output logic [OUT_COUNT_W-1:0] byte_count,
	output logic                   count_overflow
);

	logic       q_valid;
	item_t      q_item;
	logic       q_pop;
	bk_status_t bk_status;

	ckcrc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.end_of_file (end_of_file),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	ckcrc_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.status         (bk_status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.checksum       (checksum),
		.byte_count     (byte_count),
		.count_overflow (count_overflow)
	);

	`ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "pop from empty request queue")
	`ASSERT_NEVER(a_no_pop_folding, bk_status.folding && q_pop, "pop during length folding")
	`ASSERT_IMPL(a_result_from_fold, $rose(out_valid), $past(bk_status.folding),
		"result loaded outside length folding")

endmodule
